### src/mgg_pkg.sv
// ----------------------------------------------------------------------------
// mgg_pkg
// Shared types and codes for the masked gate gadget unit.
// ----------------------------------------------------------------------------
package mgg_pkg;

  localparam int SHARE_W = 5;
  localparam int RAND_W  = 64;
  localparam int ACT_W   = 3;

  localparam logic [ACT_W-1:0] ACT_ENCODE  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DECODE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REFRESH = 3'd2;
  localparam logic [ACT_W-1:0] ACT_XOR     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_AND     = 3'd4;
  localparam logic [ACT_W-1:0] ACT_NOT     = 3'd5;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [SHARE_W-1:0] x_share;
    logic [SHARE_W-1:0] y_share;
    logic [RAND_W-1:0]  random_bits;
  } mgg_item_t;

  typedef struct packed {
    logic [SHARE_W-1:0] result_share;
    logic               decoded_bit;
  } mgg_result_t;

endpackage

### src/mgg_refresh.sv
// ----------------------------------------------------------------------------
// mgg_refresh
// Refresh gadget: re-randomizes the shares of one masked bit.
// ----------------------------------------------------------------------------
module mgg_refresh #(
  parameter int LINEAR_SHARES = 2
) (
  input  logic [2:0]                                       a_in,
  input  logic [LINEAR_SHARES-1:0]                         b_in,
  input  logic [LINEAR_SHARES*(LINEAR_SHARES-1)/2+3:0]     rnd,
  output logic [2:0]                                       a_out,
  output logic [LINEAR_SHARES-1:0]                         b_out
);

  localparam int N  = LINEAR_SHARES;
  localparam int RW = N * (N - 1) / 2 + 4;

  logic [2:0] r;
  logic       q;
  logic       w;
  logic       rr;

  assign r = rnd[2:0];
  assign q = rnd[RW-1];

  // nonlinear part correction folded into the last linear share
  assign w = ((r[2] & (a_in[0] ^ q)) & (r[1] ^ a_in[1] ^ q))
           ^ ((r[1] & (a_in[2] ^ q)) & (r[0] ^ a_in[0] ^ q))
           ^ ((r[0] & (a_in[1] ^ q)) & (r[2] ^ a_in[2] ^ q));
  assign rr = ((r[0] ^ q) & (r[1] ^ q) & (r[2] ^ q))
            ^ (q & ((r[2] & (a_in[0] ^ q)) ^ (r[1] & (a_in[0] ^ q))
                  ^ (r[0] & (a_in[1] ^ q))))
            ^ (q & ((r[2] & (a_in[1] ^ q)) ^ (r[1] & (a_in[2] ^ q))
                  ^ (r[0] & (a_in[2] ^ q))))
            ^ q;

  assign a_out = a_in ^ r;

  always_comb begin
    int k;
    logic [N-1:0] b;
    k = 0;
    b = b_in;
    // one fresh bit per pair of linear shares, row order
    for (int i = 0; i < N; i++) begin
      for (int j = i + 1; j < N; j++) begin
        b[i] = b[i] ^ rnd[3+k];
        b[j] = b[j] ^ rnd[3+k];
        k = k + 1;
      end
    end
    b[N-1] = b[N-1] ^ w ^ rr;
    b_out = b;
  end

endmodule

### src/mgg_gadget.sv
// ----------------------------------------------------------------------------
// mgg_gadget
// Gadget datapath: encode, decode, refresh, masked XOR, masked AND and NOT.
// ----------------------------------------------------------------------------
module mgg_gadget #(
  parameter int LINEAR_SHARES = 2
) (
  input  mgg_pkg::mgg_item_t   item,
  output mgg_pkg::mgg_result_t result
);

  import mgg_pkg::*;

  localparam int N         = LINEAR_SHARES;
  localparam int RW        = N * (N - 1) / 2 + 4;
  localparam int AND_BASE  = 2 * RW;
  localparam int PAIR_BASE = AND_BASE + 3 * N;
  localparam int WW        = 3 + N;

  logic [WW-1:0]     wx;
  logic [WW-1:0]     wy;
  logic [N-1:0]      xb_in;
  logic [N-1:0]      yb_in;
  logic [2:0]        xa;
  logic [2:0]        ya;
  logic [N-1:0]      xb;
  logic [N-1:0]      yb;
  logic [RAND_W-1:0] rnd;

  // linear shares beyond the share word enter as zero
  assign wx    = WW'(item.x_share);
  assign wy    = WW'(item.y_share);
  assign xb_in = wx[WW-1:3];
  assign yb_in = wy[WW-1:3];
  assign rnd   = item.random_bits;

  mgg_refresh #(.LINEAR_SHARES(N)) u_refresh_x (
    .a_in  (wx[2:0]),
    .b_in  (xb_in),
    .rnd   (rnd[RW-1:0]),
    .a_out (xa),
    .b_out (xb)
  );

  mgg_refresh #(.LINEAR_SHARES(N)) u_refresh_y (
    .a_in  (wy[2:0]),
    .b_in  (yb_in),
    .rnd   (rnd[2*RW-1:RW]),
    .a_out (ya),
    .b_out (yb)
  );

  always_comb begin
    logic [2:0]   enc_a;
    logic [N-1:0] enc_b;
    logic [2:0]   xor_a;
    logic [N-1:0] xor_b;
    logic         u_x;
    logic [2:0]   and_a;
    logic [N-1:0] and_b;
    logic [N-1:0] ra [3];
    logic [N-1:0] rb0;
    logic [N-1:0] rbm [N];
    logic         u;
    logic         v;
    logic [N-1:0] not_b;
    logic         dec;
    logic [WW-1:0] res_w;
    int k;

    // encode
    enc_a = rnd[2:0];
    enc_b = '0;
    enc_b[N-1] = (enc_a[0] & enc_a[1] & enc_a[2]) ^ item.x_share[0];
    for (int i = 0; i < N - 1; i++) begin
      enc_b[i]   = rnd[3+i];
      enc_b[N-1] = enc_b[N-1] ^ rnd[3+i];
    end

    // masked xor on refreshed operands
    xor_a = xa ^ ya;
    u_x = (xa[1] & ((xa[2] & ya[0]) ^ (ya[2] & (xa[0] ^ ya[0]))))
        ^ (ya[1] & ((xa[2] & ya[0]) ^ (xa[0] & (xa[2] ^ ya[2]))));
    xor_b = xb ^ yb;
    xor_b[N-1] = xor_b[N-1] ^ u_x;

    // masked and on refreshed operands
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < N; j++) begin
        ra[i][j] = rnd[AND_BASE + i*N + j];
      end
    end
    and_a[0] = (xa[0] & ya[1]) ^ (^ra[0]);
    and_a[1] = (xa[1] & ya[2]) ^ (^ra[1]);
    and_a[2] = (xa[2] & ya[0]) ^ (^ra[2]);
    u = ^ra[1];
    v = ^ra[2];
    for (int j = 0; j < N; j++) begin
      rb0[j] = (xa[0] & ((xa[2] & ((xa[1] & yb[j]) ^ (ra[0][j] & ya[0])))
                        ^ (ra[1][j] & v & ya[1])))
             ^ (ya[0] & ((ya[1] & ((ya[2] & xb[j]) ^ (ra[1][j] & xa[2])))
                        ^ (ra[0][j] & u & xa[2])))
             ^ (xa[0] & ya[1] & ((ra[1][j] & xa[2] & ya[0])
                                ^ (ra[2][j] & xa[1] & ya[2])))
             ^ (ra[0][j] & xa[1] & ya[2] & (v ^ (xa[2] & ya[0])))
             ^ (xa[2] & ya[0] & ((ra[0][j] & xa[0]) ^ (ra[1][j] & ya[1])))
             ^ (u & v & ra[0][j]);
    end
    for (int i = 0; i < N; i++) begin
      rbm[i] = '0;
    end
    k = 0;
    for (int i = 0; i < N; i++) begin
      for (int j = i + 1; j < N; j++) begin
        rbm[i][j] = rnd[PAIR_BASE + k];
        rbm[j][i] = rnd[PAIR_BASE + k] ^ (xb[i] & yb[j]) ^ (xb[j] & yb[i]);
        k = k + 1;
      end
    end
    for (int i = 0; i < N; i++) begin
      and_b[i] = (xb[i] & yb[i]) ^ rb0[i] ^ (^rbm[i]);
    end

    // not flips the last linear share
    not_b = xb_in;
    not_b[N-1] = ~not_b[N-1];

    dec = (wx[0] & wx[1] & wx[2]) ^ (^xb_in);

    res_w = '0;
    result.decoded_bit = 1'b0;
    case (item.action)
      ACT_ENCODE:  res_w = {enc_b, enc_a};
      ACT_DECODE:  result.decoded_bit = dec;
      ACT_REFRESH: res_w = {xb, xa};
      ACT_XOR:     res_w = {xor_b, xor_a};
      ACT_AND:     res_w = {and_b, and_a};
      ACT_NOT:     res_w = {not_b, wx[2:0]};
      default:     res_w = '0;
    endcase
    // shares above the word are dropped
    result.result_share = res_w[SHARE_W-1:0];
  end

endmodule

### src/masked_gate_gadget_unit.sv
// ----------------------------------------------------------------------------
// masked_gate_gadget_unit
// Masked gate gadget unit: one masking gadget per stream word.
// ----------------------------------------------------------------------------
// Takes one word per clock while m_axis is not back-pressured and returns one
// result word per input word, in order. The edge that takes a word loads the
// input register. A later edge, once the result register is free, captures
// the gadget logic in the result register, which drives m_axis. Throughput
// is one word per cycle when m_axis_tready does not hold the result. The
// result register lets a new word enter the empty input register while the
// previous result waits on m_axis_tready. No state is kept between words.
module masked_gate_gadget_unit #(
  parameter int LINEAR_SHARES = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] x_share, [9:5] y_share, [73:10] random_bits, [79:74] zero
  input  logic [79:0] s_axis_tdata,
  // [2:0] action
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] result_share, [5] decoded_bit, [7:6] zero
  output logic [7:0]  m_axis_tdata
);

  import mgg_pkg::*;

  logic        in_valid;
  mgg_item_t   item;
  logic        out_valid;
  mgg_result_t result;
  mgg_result_t gadget_res;
  logic        out_free;

  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.action      <= s_axis_tuser;
      item.x_share     <= s_axis_tdata[4:0];
      item.y_share     <= s_axis_tdata[9:5];
      item.random_bits <= s_axis_tdata[73:10];
    end
    if (in_valid && out_free) begin
      result <= gadget_res;
    end
  end

  mgg_gadget #(.LINEAR_SHARES(LINEAR_SHARES)) u_gadget (
    .item   (item),
    .result (gadget_res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, result.decoded_bit, result.result_share};

endmodule

### tb/tb_masked_gate_gadget_unit.sv
// ----------------------------------------------------------------------------
// tb_masked_gate_gadget_unit
// Self-checking stream testbench for the masked gate gadget unit.
// ----------------------------------------------------------------------------
// Drives encode, decode, refresh, masked XOR, masked AND, NOT and the unused
// action codes. The testbench computes each gadget from the same fresh random
// bits and compares every result word in order. It runs three throttling
// phases: a slow receiver, then a slow sender, then full rate. Between phases
// the sender holds off until every expected result has drained.
// ----------------------------------------------------------------------------
module tb_masked_gate_gadget_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mgg_pkg::*;

  localparam int LIN        = 2;
  localparam int RAND_ITEMS = 450;  // per phase

  typedef struct packed {
    logic [4:0] b;  // b[0] unused, linear shares at 1..LIN
    logic [2:0] a;
  } shares_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  mgg_item_t   pending_words[$];
  mgg_result_t expected_results[$];
  mgg_item_t   in_flight;
  mgg_result_t oldest;

  int src_idle = 0;
  int dst_idle = 0;
  bit hold_off = 1'b0;
  int errors   = 0;
  int results_seen = 0;
  int act_count[8];

  // randomness source for the gadget being predicted
  logic [63:0] rand_src;
  int          rand_pos;

  masked_gate_gadget_unit #(.LINEAR_SHARES(LIN)) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [4:0] x_share, [9:5] y_share, [73:10] random_bits
    .s_axis_tuser  (s_axis_tuser),   // [2:0] action
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // [4:0] result_share, [5] decoded_bit
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic logic take_bit();
    logic v;
    v = (rand_pos < 64) ? rand_src[rand_pos] : 1'b0;
    rand_pos++;
    return v;
  endfunction

  function automatic shares_t to_shares(logic [4:0] w);
    shares_t m;
    m = '0;
    m.a = w[2:0];
    // linear shares beyond the word enter as zero
    for (int i = 1; i <= LIN; i++)
      if (2 + i <= 4) m.b[i] = w[2+i];
    return m;
  endfunction

  function automatic logic [4:0] to_word(shares_t m);
    logic [4:0] w;
    w = '0;
    w[2:0] = m.a;
    for (int i = 1; i <= LIN; i++)
      if (2 + i <= 4) w[2+i] = m.b[i];
    return w;
  endfunction

  function automatic shares_t refresh_shares(shares_t x);
    shares_t    s;
    logic [2:0] r;
    logic       t, q, w, rr;
    for (int i = 0; i < 3; i++) r[i] = take_bit();
    s.a = x.a ^ r;
    s.b = x.b;
    s.b[0] = 1'b0;
    for (int i = 1; i <= LIN; i++)
      for (int j = i + 1; j <= LIN; j++) begin
        t = take_bit();
        s.b[i] = s.b[i] ^ t;
        s.b[j] = s.b[j] ^ t;
      end
    q = take_bit();
    w = ((r[2] & (x.a[0] ^ q)) & (r[1] ^ x.a[1] ^ q))
      ^ ((r[1] & (x.a[2] ^ q)) & (r[0] ^ x.a[0] ^ q))
      ^ ((r[0] & (x.a[1] ^ q)) & (r[2] ^ x.a[2] ^ q));
    rr = ((r[0] ^ q) & (r[1] ^ q) & (r[2] ^ q))
       ^ (q & ((r[2] & (x.a[0] ^ q)) ^ (r[1] & (x.a[0] ^ q)) ^ (r[0] & (x.a[1] ^ q))))
       ^ (q & ((r[2] & (x.a[1] ^ q)) ^ (r[1] & (x.a[2] ^ q)) ^ (r[0] & (x.a[2] ^ q))))
       ^ q;
    s.b[LIN] = s.b[LIN] ^ w ^ rr;
    return s;
  endfunction

  function automatic shares_t masked_xor(shares_t x0, shares_t y0);
    shares_t x, y, s;
    logic    u;
    x = refresh_shares(x0);
    y = refresh_shares(y0);
    s = '0;
    s.a = x.a ^ y.a;
    for (int i = 1; i < LIN; i++) s.b[i] = x.b[i] ^ y.b[i];
    u = (x.a[1] & ((x.a[2] & y.a[0]) ^ (y.a[2] & (x.a[0] ^ y.a[0]))))
      ^ (y.a[1] & ((x.a[2] & y.a[0]) ^ (x.a[0] & (x.a[2] ^ y.a[2]))));
    s.b[LIN] = x.b[LIN] ^ y.b[LIN] ^ u;
    return s;
  endfunction

  function automatic shares_t masked_and(shares_t x0, shares_t y0);
    shares_t x, y, s;
    logic    ra [0:2][0:4];
    logic    rb [0:4][0:4];
    logic    u, v;
    u = 1'b0;
    v = 1'b0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 5; j++) ra[i][j] = 1'b0;
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++) rb[i][j] = 1'b0;
    x = refresh_shares(x0);
    y = refresh_shares(y0);
    s = '0;
    for (int i = 0; i < 3; i++) begin
      s.a[i] = x.a[i] & y.a[(i+1)%3];
      for (int j = 1; j <= LIN; j++) begin
        ra[i][j] = take_bit();
        s.a[i] = s.a[i] ^ ra[i][j];
      end
    end
    for (int j = 1; j <= LIN; j++) begin
      u = u ^ ra[1][j];
      v = v ^ ra[2][j];
    end
    for (int j = 1; j <= LIN; j++)
      rb[j][0] = (x.a[0] & ((x.a[2] & ((x.a[1] & y.b[j]) ^ (ra[0][j] & y.a[0])))
                            ^ (ra[1][j] & v & y.a[1])))
               ^ (y.a[0] & ((y.a[1] & ((y.a[2] & x.b[j]) ^ (ra[1][j] & x.a[2])))
                            ^ (ra[0][j] & u & x.a[2])))
               ^ (x.a[0] & y.a[1] & ((ra[1][j] & x.a[2] & y.a[0])
                                     ^ (ra[2][j] & x.a[1] & y.a[2])))
               ^ (ra[0][j] & x.a[1] & y.a[2] & (v ^ (x.a[2] & y.a[0])))
               ^ (x.a[2] & y.a[0] & ((ra[0][j] & x.a[0]) ^ (ra[1][j] & y.a[1])))
               ^ (u & v & ra[0][j]);
    for (int i = 1; i <= LIN; i++)
      for (int j = i + 1; j <= LIN; j++) begin
        rb[i][j] = take_bit();
        rb[j][i] = rb[i][j] ^ (x.b[i] & y.b[j]) ^ (x.b[j] & y.b[i]);
      end
    for (int i = 1; i <= LIN; i++) begin
      s.b[i] = x.b[i] & y.b[i];
      for (int j = 0; j <= LIN; j++)
        if (j != i) s.b[i] = s.b[i] ^ rb[i][j];
    end
    return s;
  endfunction

  function automatic mgg_result_t gadget_result(mgg_item_t it);
    mgg_result_t res;
    shares_t     x, y, s;
    logic        t;
    res = '0;
    x = to_shares(it.x_share);
    y = to_shares(it.y_share);
    rand_src = it.random_bits;
    rand_pos = 0;
    case (it.action)
      ACT_ENCODE: begin
        s = '0;
        for (int i = 0; i < 3; i++) s.a[i] = take_bit();
        s.b[LIN] = (&s.a) ^ it.x_share[0];
        for (int i = 1; i < LIN; i++) begin
          s.b[i] = take_bit();
          s.b[LIN] = s.b[LIN] ^ s.b[i];
        end
        res.result_share = to_word(s);
      end
      ACT_DECODE: begin
        t = &x.a;
        for (int i = 1; i <= LIN; i++) t = t ^ x.b[i];
        res.decoded_bit = t;
      end
      ACT_REFRESH: res.result_share = to_word(refresh_shares(x));
      ACT_XOR:     res.result_share = to_word(masked_xor(x, y));
      ACT_AND:     res.result_share = to_word(masked_and(x, y));
      ACT_NOT: begin
        s = x;
        s.b[LIN] = ~s.b[LIN];
        res.result_share = to_word(s);
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------- helpers
  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic queue_word(input logic [2:0] act, input logic [4:0] xs,
                            input logic [4:0] ys, input logic [63:0] rnd);
    mgg_item_t it;
    it.action      = act;
    it.x_share     = xs;
    it.y_share     = ys;
    it.random_bits = rnd;
    pending_words.push_back(it);
  endtask

  task automatic queue_random_word();
    logic [2:0]  act;
    logic [63:0] rnd;
    // mostly real gadgets, now and then an unused code
    act = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
    case ($urandom_range(15))
      0:       rnd = '0;
      1:       rnd = '1;
      default: rnd = {$urandom, $urandom};
    endcase
    queue_word(act, 5'($urandom), 5'($urandom), rnd);
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(gadget_result(in_flight));
        act_count[in_flight.action]++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words.size() != 0 && !hold_off && $urandom_range(99) >= src_idle) begin
          in_flight = pending_words.pop_front();
          s_axis_tdata  <= {6'd0, in_flight.random_bits, in_flight.y_share, in_flight.x_share};
          s_axis_tuser  <= in_flight.action;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %h", m_axis_tdata));
        end else begin
          oldest = expected_results.pop_front();
          if (m_axis_tdata[4:0] !== oldest.result_share)
            report_mismatch($sformatf("result_share got %h want %h",
                                      m_axis_tdata[4:0], oldest.result_share));
          if (m_axis_tdata[5] !== oldest.decoded_bit)
            report_mismatch($sformatf("decoded_bit got %b want %b",
                                      m_axis_tdata[5], oldest.decoded_bit));
          if (m_axis_tdata[7:6] !== 2'b00)
            report_mismatch($sformatf("pad bits got %b", m_axis_tdata[7:6]));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= dst_idle);
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    // directed: both plain bits, extreme randomness, every gadget, unused codes
    queue_word(ACT_ENCODE,  5'd0,  5'd0,  64'd0);
    queue_word(ACT_ENCODE,  5'd1,  5'd0,  64'd0);
    queue_word(ACT_ENCODE,  5'd0,  5'd31, '1);
    queue_word(ACT_ENCODE,  5'd31, 5'd0,  '1);
    queue_word(ACT_DECODE,  5'd0,  5'd0,  '1);
    queue_word(ACT_DECODE,  5'd31, 5'd0,  '1);
    queue_word(ACT_DECODE,  5'd7,  5'd31, 64'd0);
    queue_word(ACT_DECODE,  5'd8,  5'd0,  64'd0);
    queue_word(ACT_DECODE,  5'd24, 5'd0,  64'd0);
    queue_word(ACT_REFRESH, 5'd0,  5'd0,  64'd0);
    queue_word(ACT_REFRESH, 5'd31, 5'd31, '1);
    queue_word(ACT_REFRESH, 5'd7,  5'd0,  64'h5555_5555_5555_5555);
    queue_word(ACT_XOR,     5'd0,  5'd0,  64'd0);
    queue_word(ACT_XOR,     5'd31, 5'd31, '1);
    queue_word(ACT_XOR,     5'd7,  5'd24, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_word(ACT_AND,     5'd0,  5'd0,  64'd0);
    queue_word(ACT_AND,     5'd31, 5'd31, '1);
    queue_word(ACT_AND,     5'd7,  5'd7,  64'd0);
    queue_word(ACT_AND,     5'd24, 5'd7,  64'h0F0F_0F0F_0F0F_0F0F);
    queue_word(ACT_NOT,     5'd0,  5'd31, '1);
    queue_word(ACT_NOT,     5'd31, 5'd0,  64'd0);
    queue_word(3'd6,        5'd31, 5'd31, '1);
    queue_word(3'd7,        5'd31, 5'd31, '1);

    for (int ph = 0; ph < 3; ph++) begin
      @(negedge clk);
      case (ph)
        0:       begin src_idle = 28; dst_idle = 49; end
        1:       begin src_idle = 49; dst_idle = 28; end
        default: begin src_idle = 0;  dst_idle = 0;  end
      endcase
      for (int n = 0; n < RAND_ITEMS; n++) queue_random_word();
      hold_off = 1'b0;
      while (pending_words.size() != 0 || s_axis_tvalid) @(negedge clk);
      // drain everything before the next phase
      @(negedge clk) hold_off = 1'b1;
      while (expected_results.size() != 0) @(negedge clk);
    end

    repeat (10) @(posedge clk);
    $display("Ran %0d words: encode %0d, decode %0d, refresh %0d, xor %0d, and %0d, not %0d,",
             results_seen, act_count[ACT_ENCODE], act_count[ACT_DECODE],
             act_count[ACT_REFRESH], act_count[ACT_XOR], act_count[ACT_AND],
             act_count[ACT_NOT]);
    $display("unused codes %0d, over slow-sender, slow-receiver and full-rate phases; %0d errors",
             act_count[6] + act_count[7], errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
